>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/pims_pkg.sv
`timescale 1ns / 1ps

package pims_pkg;

	// Request modes.
	localparam logic [1:0] MODE_SPIN_WRITE  = 2'd0;
	localparam logic [1:0] MODE_TABLE_WRITE = 2'd1;
	localparam logic [1:0] MODE_UPDATE      = 2'd2;
	localparam logic [1:0] MODE_SPIN_READ   = 2'd3;

	// Acceptance table: five nearest-neighbour levels by five plaquette levels.
	localparam int unsigned TABLE_DEPTH = 25;
	localparam int unsigned TAB_AW      = 5;
	localparam int unsigned THR_W       = 33;
	localparam int unsigned RND_W       = 32;

	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       address;
		logic             spin_in;
		logic [THR_W-1:0] threshold;
		logic [RND_W-1:0] random;
	} req_t;

	typedef struct packed {
		logic [7:0] site;
		logic       spin_out;
		logic       flipped;
		logic       random_used;
		logic       sweep_done;
	} rsp_t;

endpackage

>>> rtl/pims_spin_ram.sv
`timescale 1ns / 1ps

// One-bit spin store: one write port and two read ports, read data registered.
module pims_spin_ram #(
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic          rdata_a,
	output logic          rdata_b
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/plaquette_ising_metropolis_sweep.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// request | in        | req_valid, req_ready | req (pims_pkg::req_t)
// result  | out       | rsp_valid, rsp_ready | rsp (pims_pkg::rsp_t)
//
// A site update passes through the accept cycle, which issues the first pair of
// spin reads, the read state issuing the further pairs on the two read ports of the
// spin store, a table read, the decision with write-back, and the result state that
// hands the result to the output. Spin read data and table read data are registered.
// Reset sets the sweep position to the first site; spins and table are undefined until loaded.
// A result that is not taken holds the block in its result state; one more request may be
// accepted meanwhile, since the output register keeps the waiting result.
`include "assert_macros.svh"

module plaquette_ising_metropolis_sweep #(
	parameter int unsigned LATTICE_SIDE = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pims_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pims_pkg::rsp_t rsp
);

	localparam int unsigned SIDE  = LATTICE_SIDE;
	localparam int unsigned SITES = SIDE * SIDE;
	localparam int unsigned AW    = $clog2(SITES);
	localparam int unsigned RW    = $clog2(SIDE);
	localparam logic [2:0]  LAST_STEP = 3'd4;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HREAD  = 6'b000010,
		S_READ   = 6'b000100,
		S_TAB    = 6'b001000,
		S_DECIDE = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	// Neighbourhood gathered from the spin store, one bit per spin, 1 meaning +1.
	typedef struct packed {
		logic s;
		logic up;
		logic dn;
		logic lf;
		logic rt;
		logic ul;
		logic ur;
		logic dl;
	} nbhd_t;

	state_t       state_q;
	logic [2:0]   step_q;
	logic [RW-1:0] sweep_row_q;
	logic [RW-1:0] sweep_col_q;
	logic [1:0]   sweep_phase_q;

	nbhd_t        nb_q;
	logic [7:0]   addr_q;
	logic         addr_ok_q;
	logic [pims_pkg::RND_W-1:0] random_q;
	pims_pkg::rsp_t res_q;
	pims_pkg::rsp_t rsp_q;
	logic         rsp_valid_q;

	logic [pims_pkg::THR_W-1:0] tab_mem [pims_pkg::TABLE_DEPTH];
	logic [pims_pkg::THR_W-1:0] tab_rd_q;

	logic         accept;
	logic         out_free;
	logic         req_site_ok;
	logic [RW-1:0] row_up, row_dn, col_lf, col_rt;
	logic [AW-1:0] cur_site;
	logic [AW-1:0] pair_a, pair_b;
	logic [2:0]   rd_step;
	logic [AW-1:0] rd_addr_a;
	logic         rd_a, rd_b;
	logic         spin_we;
	logic [AW-1:0] spin_waddr;
	logic         spin_wdata;
	logic         tab_we;
	logic [pims_pkg::TAB_AW-1:0] tab_idx;
	logic         always_acc;
	logic         flip;
	logic [RW:0]  col_step, row_step;
	logic [1:0]   phase_next;
	logic [RW-1:0] row_next, col_next;
	logic         done_next;

	// Site index of a lattice position.
	function automatic logic [AW-1:0] site_of(input logic [RW-1:0] row, input logic [RW-1:0] col);
		return AW'(row) * AW'(SIDE) + AW'(col);
	endfunction

	// Table index 5*e1i + e2i. The nearest-neighbour level is the number of
	// neighbours aligned with the centre spin; the plaquette level is the number
	// of four-spin products (centre, corner, side, up or down) that come out positive.
	function automatic logic [pims_pkg::TAB_AW-1:0] table_index(input nbhd_t n, input logic dr);
		logic [2:0] e1i;
		logic [2:0] e2i;
		e1i = 3'(!(n.s ^ n.up)) + 3'(!(n.s ^ n.dn)) + 3'(!(n.s ^ n.lf)) + 3'(!(n.s ^ n.rt));
		e2i = 3'(!(n.s ^ n.ul ^ n.lf ^ n.up)) + 3'(!(n.s ^ n.ur ^ n.rt ^ n.up))
			+ 3'(!(n.s ^ n.dl ^ n.lf ^ n.dn)) + 3'(!(n.s ^ dr ^ n.rt ^ n.dn));
		return pims_pkg::TAB_AW'(e1i) * pims_pkg::TAB_AW'(5) + pims_pkg::TAB_AW'(e2i);
	endfunction

	assign req_ready   = (state_q == S_IDLE);
	assign accept      = req_valid && req_ready;
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign req_site_ok = (32'(req.address) < SITES);
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// Periodic neighbours of the current sweep position.
	always_comb begin
		row_up = (sweep_row_q == '0) ? RW'(SIDE - 1) : sweep_row_q - 1'b1;
		row_dn = (sweep_row_q == RW'(SIDE - 1)) ? '0 : sweep_row_q + 1'b1;
		col_lf = (sweep_col_q == '0) ? RW'(SIDE - 1) : sweep_col_q - 1'b1;
		col_rt = (sweep_col_q == RW'(SIDE - 1)) ? '0 : sweep_col_q + 1'b1;
		cur_site = site_of(sweep_row_q, sweep_col_q);
	end

	// Read schedule: the nine spins of the neighbourhood in five pairs.
	assign rd_step = (state_q == S_READ) ? step_q : 3'd0;

	always_comb begin
		case (rd_step)
			3'd0: begin
				pair_a = cur_site;
				pair_b = site_of(row_up, sweep_col_q);
			end
			3'd1: begin
				pair_a = site_of(row_dn, sweep_col_q);
				pair_b = site_of(sweep_row_q, col_lf);
			end
			3'd2: begin
				pair_a = site_of(sweep_row_q, col_rt);
				pair_b = site_of(row_up, col_lf);
			end
			3'd3: begin
				pair_a = site_of(row_up, col_rt);
				pair_b = site_of(row_dn, col_lf);
			end
			default: begin
				pair_a = site_of(row_dn, col_rt);
				pair_b = pair_a;
			end
		endcase
	end

	assign rd_addr_a = (state_q == S_IDLE && req.mode != pims_pkg::MODE_UPDATE)
		? AW'(req.address) : pair_a;

	// Host writes land in the accept cycle; an update writes back in its
	// decision cycle, after all of its reads, so no access overlaps another.
	always_comb begin
		if (state_q == S_DECIDE) begin
			spin_we    = flip;
			spin_waddr = cur_site;
			spin_wdata = ~nb_q.s;
		end else begin
			spin_we    = accept && req.mode == pims_pkg::MODE_SPIN_WRITE && req_site_ok;
			spin_waddr = AW'(req.address);
			spin_wdata = req.spin_in;
		end
	end

	pims_spin_ram #(
		.DEPTH(SITES)
	) u_spin_ram (
		.clk    (clk),
		.we     (spin_we),
		.waddr  (spin_waddr),
		.wdata  (spin_wdata),
		.raddr_a(rd_addr_a),
		.raddr_b(pair_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// Acceptance table store.
	assign tab_we  = accept && req.mode == pims_pkg::MODE_TABLE_WRITE
		&& 32'(req.address) < pims_pkg::TABLE_DEPTH;
	assign tab_idx = table_index(nb_q, rd_a);

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[req.address[pims_pkg::TAB_AW-1:0]] <= req.threshold;
		end
		tab_rd_q <= tab_mem[tab_idx];
	end

	// Decision: an entry of 2^32 or more accepts without the random number.
	assign always_acc = tab_rd_q[pims_pkg::THR_W-1];
	assign flip = always_acc || (random_q < tab_rd_q[pims_pkg::RND_W-1:0]);

	// Next site in four-sublattice order.
	always_comb begin
		col_step   = (RW + 1)'(sweep_col_q) + (RW + 1)'(2);
		row_step   = (RW + 1)'(sweep_row_q) + (RW + 1)'(2);
		phase_next = sweep_phase_q;
		row_next   = sweep_row_q;
		col_next   = sweep_col_q;
		done_next  = 1'b0;
		if (32'(col_step) < SIDE) begin
			col_next = col_step[RW-1:0];
		end else if (32'(row_step) < SIDE) begin
			row_next = row_step[RW-1:0];
			col_next = RW'(sweep_phase_q[0]);
		end else begin
			phase_next = sweep_phase_q + 2'd1;
			row_next   = RW'(phase_next[1]);
			col_next   = RW'(phase_next[0]);
			done_next  = (phase_next == 2'd0);
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			sweep_row_q   <= '0;
			sweep_col_q   <= '0;
			sweep_phase_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.mode)
							pims_pkg::MODE_UPDATE: begin
								step_q  <= 3'd1;
								state_q <= S_READ;
							end
							pims_pkg::MODE_SPIN_READ: state_q <= S_HREAD;
							default:                  state_q <= S_RESP;
						endcase
					end
				end
				S_HREAD: state_q <= S_RESP;
				S_READ: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_TAB;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_TAB: state_q <= S_DECIDE;
				S_DECIDE: begin
					sweep_row_q   <= row_next;
					sweep_col_q   <= col_next;
					sweep_phase_q <= phase_next;
					state_q       <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers: request fields, gathered spins, pending and shown result.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q    <= req.address;
			addr_ok_q <= req_site_ok;
			random_q  <= req.random;
			res_q     <= '{site: req.address,
				spin_out: (req.mode == pims_pkg::MODE_SPIN_WRITE) && req_site_ok && req.spin_in,
				flipped: 1'b0, random_used: 1'b0, sweep_done: 1'b0};
		end
		if (state_q == S_HREAD) begin
			res_q <= '{site: addr_q, spin_out: addr_ok_q && rd_a,
				flipped: 1'b0, random_used: 1'b0, sweep_done: 1'b0};
		end
		if (state_q == S_READ) begin
			case (step_q)
				3'd1: begin
					nb_q.s  <= rd_a;
					nb_q.up <= rd_b;
				end
				3'd2: begin
					nb_q.dn <= rd_a;
					nb_q.lf <= rd_b;
				end
				3'd3: begin
					nb_q.rt <= rd_a;
					nb_q.ul <= rd_b;
				end
				default: begin
					nb_q.ur <= rd_a;
					nb_q.dl <= rd_b;
				end
			endcase
		end
		if (state_q == S_DECIDE) begin
			res_q <= '{site: 8'(cur_site), spin_out: nb_q.s ^ flip, flipped: flip,
				random_used: !always_acc, sweep_done: done_next};
		end
		if (state_q == S_RESP && out_free) begin
			rsp_q <= res_q;
		end
	end

	// The spin store sees no write while an update is still gathering its neighbourhood.
	`ASSERT_IMPLY(a_no_write_while_gathering, clk, arst_n, state_q == S_READ || state_q == S_TAB, !spin_we)
	// The sweep position always names a site of the lattice.
	`ASSERT_IMPLY(a_sweep_in_lattice, clk, arst_n, 1'b1, (32'(sweep_row_q) < SIDE) && (32'(sweep_col_q) < SIDE))
	// The sweep position moves only when an update is decided.
	`ASSERT_NEXT(a_sweep_moves_on_decide, clk, arst_n, state_q != S_DECIDE, $stable(sweep_row_q) && $stable(sweep_col_q) && $stable(sweep_phase_q))
	// A pending result reaches the output as soon as the output has room.
	`ASSERT_NEXT(a_result_published, clk, arst_n, state_q == S_RESP && out_free, rsp_valid_q && state_q == S_IDLE)

endmodule
